// ===== design/u8d_pkg.sv =====
// u8d_pkg: shared types and constants of the utf-8 validating decoder
// transaction structs for request, response and the internal command queue
// no dependencies
`default_nettype none

package u8d_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  byte_count;
      logic        bad_sequence;
      logic        run_last;
      logic        text_done;
      logic        text_ok;
      logic [31:0] point_total;
   } rsp_type;

   // replacements first, then an optional decoded code point
   typedef struct packed {
      logic [2:0]  n_repl;
      logic        has_good;
      logic [20:0] code_point;
      logic [2:0]  byte_count;
      logic        text_end;
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/u8d_front.sv =====
// u8d_front: accepts bytes, tracks the held sequence and classifies each byte
// into at most one command for the back end; depends on u8d_pkg
`default_nettype none

module u8d_front
   import u8d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire logic    full,
   input  wire req_type req,
   output logic         cmd_push,
   output cmd_type      cmd
);

   localparam logic [7:0] TailLo  = 8'h80;
   localparam logic [7:0] TailHi  = 8'hBF;
   localparam logic [7:0] LoE0    = 8'hA0;
   localparam logic [7:0] HiED    = 8'h9F;
   localparam logic [7:0] LoF0    = 8'h90;
   localparam logic [7:0] HiF4    = 8'h8F;

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] n;
      if (b < 8'h80) n = 3'd1;
      else if (b >= 8'hC2 && b <= 8'hDF) n = 3'd2;
      else if (b >= 8'hE0 && b <= 8'hEF) n = 3'd3;
      else if (b >= 8'hF0 && b <= 8'hF4) n = 3'd4;
      else n = 3'd0;
      return n;
   endfunction

   logic [7:0]  lead_ff, lead_in;
   logic [1:0]  count_ff, count_in;
   logic [11:0] tails_ff, tails_in;

   logic        accept;
   logic [7:0]  b;
   logic [7:0]  lo, hi;
   logic        fits;
   logic [2:0]  lead_len;
   logic [2:0]  start_len;
   logic [2:0]  n_repl;
   logic        good;
   logic [20:0] cp;
   logic [2:0]  bc;
   logic        do_start;

   assign accept = push & ~full;
   assign b      = req.in_byte;

   always_comb begin
      lo = TailLo;
      hi = TailHi;
      if (count_ff == 2'd1) begin
         if (lead_ff == 8'hE0) lo = LoE0;
         else if (lead_ff == 8'hED) hi = HiED;
         else if (lead_ff == 8'hF0) lo = LoF0;
         else if (lead_ff == 8'hF4) hi = HiF4;
      end
      fits = (b >= lo) && (b <= hi);
   end

   always_comb begin
      lead_in   = lead_ff;
      count_in  = count_ff;
      tails_in  = tails_ff;
      n_repl    = 3'd0;
      good      = 1'b0;
      cp        = 21'd0;
      bc        = 3'd1;
      do_start  = 1'b0;
      lead_len  = seq_len(lead_ff);
      if (lead_len < 3'd2) lead_len = 3'd2;
      start_len = seq_len(b);

      if (count_ff == 2'd0) begin
         do_start = 1'b1;
      end else if (fits) begin
         if ({1'b0, count_ff} + 3'd1 >= lead_len) begin
            good     = 1'b1;
            bc       = lead_len;
            count_in = 2'd0;
            case (lead_len)
               3'd2:    cp = {10'd0, lead_ff[4:0], b[5:0]};
               3'd3:    cp = {5'd0, lead_ff[3:0], tails_ff[5:0], b[5:0]};
               default: cp = {lead_ff[2:0], tails_ff, b[5:0]};
            endcase
         end else begin
            tails_in = {tails_ff[5:0], b[5:0]};
            count_in = count_ff + 2'd1;
         end
      end else begin
         n_repl   = {1'b0, count_ff};
         count_in = 2'd0;
         do_start = 1'b1;
      end

      if (do_start) begin
         case (start_len)
            3'd1: begin
               good = 1'b1;
               cp   = {13'd0, b};
               bc   = 3'd1;
            end
            3'd0: begin
               n_repl = n_repl + 3'd1;
            end
            default: begin
               lead_in  = b;
               count_in = 2'd1;
               tails_in = 12'd0;
            end
         endcase
      end

      if (req.text_end && count_in != 2'd0) begin
         n_repl   = n_repl + {1'b0, count_in};
         count_in = 2'd0;
      end
   end

   assign cmd_push       = accept & ((n_repl != 3'd0) | good);
   assign cmd.n_repl     = n_repl;
   assign cmd.has_good   = good;
   assign cmd.code_point = cp;
   assign cmd.byte_count = bc;
   assign cmd.text_end   = req.text_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= 8'd0;
         count_ff <= 2'd0;
      end else if (accept) begin
         lead_ff  <= lead_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tails_ff <= tails_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/u8d_queue.sv =====
// u8d_queue: short command queue between front and back end
// register array with head read; depends on u8d_pkg
`default_nettype none

module u8d_queue
   import u8d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type wdata,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output cmd_type      rdata
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ===== design/u8d_back.sv =====
// u8d_back: expands each command into response transactions, keeps the
// error flag and code point counter, drives the output register; uses u8d_pkg
`default_nettype none

module u8d_back
   import u8d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire cmd_type q_head,
   output logic         q_pop,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   logic [1:0]             idx_ff, idx_in;
   logic                   err_ff, err_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;

   logic                   can_load;
   logic                   adv;
   logic [2:0]             total;
   logic                   is_bad;
   logic                   is_final;
   logic                   is_done;
   logic [63:0]            cnt_wide;

   assign total    = q_head.n_repl + {2'b00, q_head.has_good};
   assign can_load = ~out_valid_ff | rsp_pop;
   assign adv      = can_load & ~q_empty;
   assign is_bad   = ({1'b0, idx_ff} < q_head.n_repl);
   assign is_final = ({1'b0, idx_ff} == total - 3'd1);
   assign is_done  = is_final & q_head.text_end;
   assign q_pop    = adv & is_final;

   always_comb begin
      idx_in       = idx_ff;
      err_in       = err_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      cnt_wide     = 64'd0;
      if (adv) begin
         idx_in = is_final ? 2'd0 : idx_ff + 2'd1;
         if (cnt_ff != {COUNT_WIDTH{1'b1}}) cnt_in = cnt_ff + 1'b1;
         cnt_wide = 64'(cnt_in);
         out_in.code_point   = is_bad ? REPLACEMENT_CHAR : q_head.code_point;
         out_in.byte_count   = is_bad ? 3'd1 : q_head.byte_count;
         out_in.bad_sequence = is_bad;
         out_in.run_last     = is_final;
         out_in.text_done    = is_done;
         out_in.text_ok      = is_done & ~(err_ff | is_bad);
         out_in.point_total  = cnt_wide[31:0];
         out_valid_in        = 1'b1;
         if (is_done) begin
            err_in = 1'b0;
            cnt_in = '0;
         end else begin
            err_in = err_ff | is_bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         err_ff       <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         err_ff       <= err_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> ({1'b0, idx_ff} < total))
      else $error("sub-result index beyond command length");

   a_ok_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.text_ok) |-> out_ff.text_done)
      else $error("text_ok without text_done");

   a_bad_is_replacement: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.bad_sequence) |->
         (out_ff.code_point == REPLACEMENT_CHAR && out_ff.byte_count == 3'd1))
      else $error("replacement with wrong payload");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && is_done) |=> (cnt_ff == '0 && !err_ff))
      else $error("text state not cleared after final transaction");
`endif

endmodule

`default_nettype wire

// ===== design/utf8_validating_decoder_top.sv =====
// utf8_validating_decoder_top: streaming utf-8 decoder with U+FFFD replacement
// front classifier, command queue, back expander; uses u8d_pkg and submodules
//
//   channel   direction  handshake            payload
//   req_      in         req_push / req_full  req_data   (req_type)
//   rsp_      out        rsp_pop / rsp_empty  rsp_data   (rsp_type)
//
// one byte per cycle is accepted while the command queue has room
// each byte gives zero to four back end response transactions, one per cycle if popped
// first response of a byte passes the command queue and the output register to rsp_data
// one byte per cycle holds while rsp_pop is high and bytes average at most one response
// with rsp_pop low, bytes are taken until the four-entry queue fills
// reset is synchronous and clears held sequence, queue, counter and output valid
`default_nettype none

module utf8_validating_decoder_top
   import u8d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   logic    cmd_push;
   cmd_type cmd;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   cmd_type q_head;

   assign req_full = q_full;

   u8d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (q_full),
      .req      (req_data),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   u8d_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_head)
   );

   u8d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
